// File: hw/rtl/breakpoint_table_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Breakpoint table interpolator assertion macros
// Shared forms of the concurrent checks used by the interpolator.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_MACROS_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_MACROS_SVH

// Checks a consequence in the same cycle as its antecedent.
`define BTI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define BTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint table interpolator package
// Field widths, item mode codes, register indexes and weight constants.
// ----------------------------------------------------------------------------
package bti_pkg;

    localparam int MODE_W    = 3;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 1;

    typedef logic [MODE_W-1:0]       t_mode;
    typedef logic [IDX_W-1:0]        t_index;
    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;

    localparam t_mode MODE_LOAD_X   = 3'd0;
    localparam t_mode MODE_LOAD_Y   = 3'd1;
    localparam t_mode MODE_LOAD_Z   = 3'd2;
    localparam t_mode MODE_QUERY_1D = 3'd3;
    localparam t_mode MODE_QUERY_2D = 3'd4;

    localparam t_cfg_idx CFG_X_COUNT = 1'd0;
    localparam t_cfg_idx CFG_Y_COUNT = 1'd1;

    localparam int          WSH     = 30;
    localparam logic [30:0] ONE_W   = 31'h4000_0000;
    localparam longint      EPS_INV = 100000;

endpackage

// File: hw/rtl/bti_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolator input channel
// Carries one load or query item per handshake.
// ----------------------------------------------------------------------------
interface bti_in_if;
    import bti_pkg::*;

    logic   valid;
    logic   ready;
    t_mode  mode;
    t_index entry_index;
    t_value entry_value;
    t_value query_x;
    t_value query_y;

    modport source (output valid, mode, entry_index, entry_value, query_x, query_y,
                    input ready);
    modport sink   (input valid, mode, entry_index, entry_value, query_x, query_y,
                    output ready);
endinterface

// File: hw/rtl/bti_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolator output channel
// Carries one interpolated result item per handshake.
// ----------------------------------------------------------------------------
interface bti_out_if;
    import bti_pkg::*;

    logic   valid;
    logic   ready;
    t_value result_value;
    logic   status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

// File: hw/rtl/breakpoint_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint table interpolator
// Holds X, Y and Z breakpoint tables in memories and answers 1D and 2D
// interpolation queries in signed fixed point.
// ----------------------------------------------------------------------------
// Items arrive on i_in. Load items write one table entry in the cycle they are
// accepted and produce no result. Query items produce one result item on o_out.
// Table sizes in use come from the write port i_cfg_we, i_cfg_idx, i_cfg_data.
// A 1D query that is clamped to an axis end skips the scan and the divider;
// the slowest 1D query is a point inside the last segment of a full axis
// that needs the divider. Query time is set by the breakpoint scan, which
// reads one axis entry per cycle through the shared axis read address, and
// by the 30 step bit-serial weight divider, run at most once per axis.
// One item is worked on at a time; i_in.ready is high while the block is idle.
// A finished result sits in an output register, so the next item is accepted
// while it waits. If the receiver stalls, the next result waits in the
// final state until the output register frees up.
// Reset sets both counts to two and empties the output register; the table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "breakpoint_table_interpolator_macros.svh"

module breakpoint_table_interpolator #(
    parameter int MAX_X_POINTS = 32,
    parameter int MAX_Y_POINTS = 32,
    parameter int FRAC_BITS    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    bti_in_if.sink                   i_in,
    bti_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  bti_pkg::t_cfg_idx        i_cfg_idx,
    input  bti_pkg::t_count          i_cfg_data
);
    import bti_pkg::*;

    localparam int YT_LEN = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int ZG_LEN = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int XAW    = $clog2(MAX_X_POINTS);
    localparam int AW     = $clog2(YT_LEN);
    localparam int NW     = $clog2(YT_LEN + 1);
    localparam int ZAW    = $clog2(ZG_LEN);
    localparam longint FLAT_MAX = ((longint'(1) << FRAC_BITS) - 1) / EPS_INV;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_L0   = 4'd1;
    localparam logic [3:0] S_L1   = 4'd2;
    localparam logic [3:0] S_L2   = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_P0   = 4'd5;
    localparam logic [3:0] S_P1   = 4'd6;
    localparam logic [3:0] S_P2   = 4'd7;
    localparam logic [3:0] S_W0   = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_WD   = 4'd10;
    localparam logic [3:0] S_ZB   = 4'd11;
    localparam logic [3:0] S_ZRD  = 4'd12;
    localparam logic [3:0] S_MUL  = 4'd13;
    localparam logic [3:0] S_ACC  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    localparam logic [2:0] K_LAST_2D = 3'd5;
    localparam logic [2:0] K_1D      = 3'd6;

    function automatic logic [NW-1:0] clamp_cnt(input t_count v, input int lo, input int hi);
        int r;
        r = int'(v);
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return NW'(r);
    endfunction

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd536870912;
        return t >>> WSH;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)  return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    logic signed [31:0] mem_x [MAX_X_POINTS];
    logic signed [31:0] mem_y [YT_LEN];
    logic signed [31:0] mem_z [ZG_LEN];

    logic [3:0]         r_state;
    t_count             r_x_count;
    t_count             r_y_count;
    logic               r_mode2d;
    logic               r_axis;
    logic               r_asc;
    logic               r_end;
    logic               r_flat;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_nx;
    logic [NW-1:0]      r_ny;
    logic signed [31:0] r_q;
    logic signed [31:0] r_qy;
    logic signed [31:0] r_a0;
    logic signed [31:0] r_qc;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    logic signed [31:0] r_ylo;
    logic signed [31:0] r_yhi;
    logic [AW-1:0]      r_i;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_ix;
    logic [AW-1:0]      r_iy;
    logic [32:0]        r_ad;
    logic [32:0]        r_rem;
    logic [29:0]        r_quo;
    logic [4:0]         r_cnt;
    logic [30:0]        r_w;
    logic [30:0]        r_t;
    logic [30:0]        r_u;
    logic [ZAW-1:0]     r_zb;
    logic [2:0]         r_k;
    logic signed [31:0] r_zs [4];
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [33:0] r_a;
    logic signed [33:0] r_b;
    logic signed [31:0] r_res;
    logic signed [31:0] r_xrd;
    logic signed [31:0] r_yrd;
    logic signed [31:0] r_zrd;
    logic               r_ovalid;
    t_value             r_oval;
    logic               r_ostat;

    logic               accept;
    logic [31:0]        ei32;
    logic [AW-1:0]      rd_addr;
    logic [ZAW-1:0]     z_addr;
    logic signed [31:0] ax_d;
    logic               scan_hit;
    logic               before_first;
    logic               beyond_last;
    logic               asc_now;
    logic signed [32:0] num33;
    logic signed [32:0] den33;
    logic [32:0]        an;
    logic [32:0]        ad;
    logic               sign_off;
    logic [33:0]        rem2;
    logic               ge;
    logic [32:0]        n_rem;
    logic [29:0]        n_quo;
    logic signed [32:0] dy33;
    logic signed [33:0] ma;
    logic signed [31:0] mb;
    logic signed [65:0] mul_full;
    logic signed [63:0] acc_sum;
    logic signed [63:0] rnd_sum;
    logic signed [63:0] one_d;
    logic               out_free;

    assign accept       = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign ei32         = 32'(i_in.entry_index);
    assign o_out.valid  = r_ovalid;
    assign o_out.result_value = r_oval;
    assign o_out.status = r_ostat;
    assign out_free     = !r_ovalid || o_out.ready;

    always_comb begin
        unique case (r_state)
            S_L1:    rd_addr = AW'(r_n - NW'(1));
            S_L2:    rd_addr = AW'(1);
            S_SCAN:  rd_addr = r_i + AW'(2);
            S_P0:    rd_addr = r_idx;
            S_P1:    rd_addr = r_idx + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        case (r_k)
            3'd1:    z_addr = r_zb + ZAW'(1);
            3'd2:    z_addr = r_zb + ZAW'(r_nx);
            3'd3:    z_addr = r_zb + ZAW'(r_nx) + ZAW'(1);
            default: z_addr = r_zb;
        endcase
    end

    assign ax_d         = r_axis ? r_yrd : r_xrd;
    assign asc_now      = !(r_a0 > ax_d);
    assign before_first = asc_now ? (r_q <= r_a0) : (r_q >= r_a0);
    assign beyond_last  = asc_now ? (r_q >= ax_d) : (r_q <= ax_d);
    assign scan_hit     = (r_asc ? (r_q <= ax_d) : (r_q >= ax_d))
                          || ((int'(r_i) + 2) >= int'(r_n));

    assign num33    = {r_qc[31], r_qc} - {r_lo[31], r_lo};
    assign den33    = {r_hi[31], r_hi} - {r_lo[31], r_lo};
    assign an       = num33[32] ? 33'(-num33) : num33;
    assign ad       = den33[32] ? 33'(-den33) : den33;
    assign sign_off = (num33[32] != den33[32]) && (num33 != '0);

    assign rem2  = {r_rem, 1'b0};
    assign ge    = rem2 >= {1'b0, r_ad};
    assign n_rem = ge ? 33'(rem2 - {1'b0, r_ad}) : rem2[32:0];
    assign n_quo = {r_quo[28:0], ge};

    assign dy33 = {r_yhi[31], r_yhi} - {r_ylo[31], r_ylo};

    always_comb begin
        case (r_k)
            3'd0: begin
                ma = {{2{r_zs[0][31]}}, r_zs[0]};
                mb = $signed({1'b0, ONE_W - r_t});
            end
            3'd1: begin
                ma = {{2{r_zs[1][31]}}, r_zs[1]};
                mb = $signed({1'b0, r_t});
            end
            3'd2: begin
                ma = {{2{r_zs[2][31]}}, r_zs[2]};
                mb = $signed({1'b0, ONE_W - r_t});
            end
            3'd3: begin
                ma = {{2{r_zs[3][31]}}, r_zs[3]};
                mb = $signed({1'b0, r_t});
            end
            3'd4: begin
                ma = r_a;
                mb = $signed({1'b0, ONE_W - r_u});
            end
            3'd5: begin
                ma = r_b;
                mb = $signed({1'b0, r_u});
            end
            default: begin
                ma = {dy33[32], dy33};
                mb = $signed({1'b0, r_t});
            end
        endcase
    end

    assign mul_full = ma * mb;
    assign acc_sum  = r_acc + r_prod;
    assign rnd_sum  = rnd(acc_sum);
    assign one_d    = {{32{r_ylo[31]}}, r_ylo} + rnd(r_prod);

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.mode == MODE_LOAD_X) && (ei32 < 32'(MAX_X_POINTS))) begin
            mem_x[ei32[XAW-1:0]] <= i_in.entry_value;
        end
        r_xrd <= mem_x[rd_addr[XAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.mode == MODE_LOAD_Y) && (ei32 < 32'(YT_LEN))) begin
            mem_y[ei32[AW-1:0]] <= i_in.entry_value;
        end
        r_yrd <= mem_y[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.mode == MODE_LOAD_Z) && (ei32 < 32'(ZG_LEN))) begin
            mem_z[ei32[ZAW-1:0]] <= i_in.entry_value;
        end
        r_zrd <= mem_z[z_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_count <= CNT_W'(2);
            r_y_count <= CNT_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_COUNT: r_x_count <= i_cfg_data;
                CFG_Y_COUNT: r_y_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
                r_oval   <= r_res;
                r_ostat  <= r_flat;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_axis <= 1'b0;
                        r_flat <= 1'b0;
                        r_q    <= i_in.query_x;
                        r_qy   <= i_in.query_y;
                        case (i_in.mode)
                            MODE_QUERY_1D: begin
                                r_mode2d <= 1'b0;
                                r_n      <= clamp_cnt(r_x_count, 1, MAX_X_POINTS);
                                r_state  <= S_L0;
                            end
                            MODE_QUERY_2D: begin
                                r_mode2d <= 1'b1;
                                r_n      <= clamp_cnt(r_x_count, 2, MAX_X_POINTS);
                                r_ny     <= clamp_cnt(r_y_count, 2, MAX_Y_POINTS);
                                r_state  <= S_L0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_L0: r_state <= S_L1;
                S_L1: begin
                    r_a0    <= ax_d;
                    r_state <= S_L2;
                end
                S_L2: begin
                    r_asc <= asc_now;
                    if (before_first) begin
                        r_idx   <= '0;
                        r_qc    <= r_a0;
                        r_end   <= !r_mode2d;
                        r_state <= S_P0;
                    end else if (beyond_last) begin
                        r_qc <= ax_d;
                        if (r_mode2d) begin
                            r_idx <= AW'(r_n - NW'(2));
                            r_end <= 1'b0;
                        end else begin
                            r_idx <= AW'(r_n - NW'(1));
                            r_end <= 1'b1;
                        end
                        r_state <= S_P0;
                    end else begin
                        r_i     <= '0;
                        r_end   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_idx   <= r_i;
                        r_qc    <= r_q;
                        r_state <= S_P0;
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_lo    <= ax_d;
                    r_ylo   <= r_yrd;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_hi  <= ax_d;
                    r_yhi <= r_yrd;
                    if (r_end) begin
                        r_res   <= r_ylo;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_W0;
                    end
                end
                S_W0: begin
                    if ({31'b0, ad} <= 64'(FLAT_MAX)) begin
                        r_w     <= '0;
                        r_flat  <= 1'b1;
                        r_state <= S_WD;
                    end else if (sign_off) begin
                        r_w     <= '0;
                        r_state <= S_WD;
                    end else if (an >= ad) begin
                        r_w     <= ONE_W;
                        r_state <= S_WD;
                    end else begin
                        r_ad    <= ad;
                        r_rem   <= an;
                        r_quo   <= '0;
                        r_cnt   <= 5'd30;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_w     <= {1'b0, n_quo};
                        r_state <= S_WD;
                    end
                end
                S_WD: begin
                    if (!r_mode2d) begin
                        r_t <= r_w;
                        r_k <= K_1D;
                        if (r_flat) begin
                            r_res   <= r_ylo;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end else if (!r_axis) begin
                        r_t     <= r_w;
                        r_ix    <= r_idx;
                        r_nx    <= r_n;
                        r_axis  <= 1'b1;
                        r_n     <= r_ny;
                        r_q     <= r_qy;
                        r_state <= S_L0;
                    end else begin
                        r_u     <= r_w;
                        r_iy    <= r_idx;
                        r_state <= S_ZB;
                    end
                end
                S_ZB: begin
                    r_zb    <= ZAW'(r_ix) + ZAW'(r_nx) * ZAW'(r_iy);
                    r_k     <= '0;
                    r_state <= S_ZRD;
                end
                S_ZRD: begin
                    if (r_k != 3'd0) begin
                        r_zs[3] <= r_zrd;
                        r_zs[2] <= r_zs[3];
                        r_zs[1] <= r_zs[2];
                        r_zs[0] <= r_zs[1];
                    end
                    if (r_k == 3'd4) begin
                        r_k     <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_full[63:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_k <= r_k + 3'd1;
                    case (r_k) inside
                        3'd0, 3'd2, 3'd4: begin
                            r_acc   <= r_prod;
                            r_state <= S_MUL;
                        end
                        3'd1: begin
                            r_a     <= rnd_sum[33:0];
                            r_state <= S_MUL;
                        end
                        3'd3: begin
                            r_b     <= rnd_sum[33:0];
                            r_state <= S_MUL;
                        end
                        K_LAST_2D: begin
                            r_res   <= sat32(rnd_sum);
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_res   <= sat32(one_d);
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BTI_ASSERT_SAME(a_div_rem_below_divisor, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_ad, "divider remainder reached the divisor")
    `BTI_ASSERT_SAME(a_scan_in_axis, i_clk, i_rst_n, r_state == S_SCAN, (int'(r_i) + 2) <= int'(r_n), "breakpoint scan ran past the axis end")
    `BTI_ASSERT_SAME(a_weight_bounded, i_clk, i_rst_n, r_state == S_MUL, r_t <= ONE_W, "interpolation weight exceeds one")
    `BTI_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_OUT) && !r_ovalid, r_ovalid && (r_state == S_IDLE), "finished result was not loaded into the output register")

endmodule
